/* hw/rtl/midi_step_sequencer_unit_assert.svh */
// Assertion macros shared by the step sequencer RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef MIDI_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define MIDI_STEP_SEQUENCER_UNIT_ASSERT_SVH

// Flag any clock edge at which a condition that must never occur is true.
`define MSS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Flag any clock edge at which the antecedent holds and the consequent does not.
`define MSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/mss_pkg.sv */
// Package for the step sequencer: sizes, codes, item and command types.
// Depends on nothing; used by every module of the block but mss_ram.
package mss_pkg;

  localparam int TRACKS          = 8;
  localparam int STEPS           = 16;
  localparam int NOTE_SLOTS      = 32;
  localparam int TICKS_PER_STEP  = 6;
  localparam int NOTE_MAX        = 127;
  localparam int ACCENT_BOOST    = 20;
  localparam int SWING_MAX       = 2;
  localparam int TRANSPOSE_LIMIT = 24;

  localparam int TRK_W   = $clog2(TRACKS);
  localparam int STP_W   = $clog2(STEPS);
  localparam int ADDR_W  = TRK_W + STP_W;
  localparam int SLOT_W  = $clog2(NOTE_SLOTS);
  localparam int CNT_W   = $clog2(NOTE_SLOTS + 1);
  localparam int ENTRY_W = 24;

  // tick / 6 as a multiply by the reciprocal
  localparam logic [31:0] DIV6_RECIP = 32'hAAAA_AAAB;
  localparam int          DIV6_SHIFT = 34;
  localparam int          QUO_W      = 30;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_SWING_TICKS    = 3'd1,
    CFG_MUTE_MASK      = 3'd2,
    CFG_SOLO_MASK      = 3'd3,
    CFG_TRANSPOSE_PACK = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_CONTINUE   = 3'd3,
    OP_WRITE_STEP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_ADVANCE  = 2'd2,
    EV_COMPLETE = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] tick_count;
    logic [2:0]  track_index;
    logic [3:0]  step_index;
    logic        step_active;
    logic [6:0]  step_note;
    logic [6:0]  step_velocity;
    logic        step_accent;
    logic [7:0]  step_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] track_out;
    logic [3:0] step_out;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic [3:0] channel_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       active;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       accent;
    logic [7:0] length;
  } step_entry_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] tick;
    logic [3:0]  step;
    logic        fire;
    logic [2:0]  track;
    step_entry_t entry;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  mute;
    logic [7:0]  solo;
    logic [47:0] transpose;
  } play_cfg_t;

endpackage

/* hw/rtl/midi_step_sequencer_unit.sv */
// Step sequencer with swing, eight tracks of sixteen steps: top level.
// A tick is first reduced in the front end: tick/6 is taken modulo the pattern
// length bit-serially (one quotient bit per cycle over 30 bits). In the back
// end a firing step visits each track (registered step-store read, then
// evaluation); every tick then walks the held note slots for release and
// marks the last result.
// Results drain through a four-entry queue; when it is full the back end holds.
// The step store is cleared by per-entry valid bits, so no clearing pass runs.
module midi_step_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  mss_pkg::in_item_t             in_item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output mss_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mss_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import mss_pkg::*;

  logic [4:0]  len_q;
  logic [1:0]  swing_q;
  logic [7:0]  mute_q, solo_q;
  logic [47:0] trn_q;
  logic [4:0]  len_eff;
  logic [1:0]  swing_eff;
  play_cfg_t   play_cfg;

  logic  item_ready, cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t  cmd_front, cmd_head;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= 5'(STEPS);
      swing_q <= 2'd0;
      mute_q  <= 8'd0;
      solo_q  <= 8'd0;
      trn_q   <= 48'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: len_q   <= cfg_data_i[4:0];
        CFG_SWING_TICKS:    swing_q <= cfg_data_i[1:0];
        CFG_MUTE_MASK:      mute_q  <= cfg_data_i[7:0];
        CFG_SOLO_MASK:      solo_q  <= cfg_data_i[7:0];
        CFG_TRANSPOSE_PACK: trn_q   <= cfg_data_i[47:0];
        default:            len_q   <= len_q;
      endcase
    end
  end

  // Clamp length to 1..STEPS and swing to at most two ticks
  assign len_eff   = (len_q == 5'd0) ? 5'd1 : ((len_q > 5'(STEPS)) ? 5'(STEPS) : len_q);
  assign swing_eff = (swing_q > 2'(SWING_MAX)) ? 2'(SWING_MAX) : swing_q;
  assign play_cfg  = '{mute: mute_q, solo: solo_q, transpose: trn_q};

  assign full = !item_ready;

  mss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (push),
    .item_i       (in_item_i),
    .item_ready_o (item_ready),
    .len_i        (len_eff),
    .swing_i      (swing_eff),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_front),
    .cmd_full_i   (cmd_full)
  );

  mss_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_front),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  mss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (play_cfg),
    .out_o       (out_item_o),
    .out_empty_o (empty),
    .out_pop_i   (pop)
  );

endmodule

/* hw/rtl/mss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mss_front.sv */
// Front end: accepts items, tracks play state, works out step and firing for ticks.
// Depends on mss_pkg; feeds commands into mss_cmd_q.
module mss_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  mss_pkg::in_item_t item_i,
  output logic             item_ready_o,
  input  logic [4:0]       len_i,
  input  logic [1:0]       swing_i,
  output logic             cmd_push_o,
  output mss_pkg::cmd_t    cmd_o,
  input  logic             cmd_full_i
);
  import mss_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_MOD, F_PUSH} front_state_e;

  front_state_e state_q, state_d;
  logic         playing_q, playing_d;
  logic [31:0]  tick_q, tick_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [4:0]   rem_q, rem_d;
  logic [4:0]   bit_q, bit_d;
  cmd_t         cmd_q, cmd_d;

  logic         accept;
  logic [63:0]  prod;
  logic [4:0]   shifted;
  logic [5:0]   low6;
  logic [2:0]   phase;
  logic         fire;
  logic         go_mul, go_push;

  assign item_ready_o = (state_q == F_IDLE);
  assign accept       = item_valid_i && item_ready_o;

  // Decode the accepted item: ticks while stopped, continue and unknown codes end here.
  always_comb begin
    go_mul  = 1'b0;
    go_push = 1'b0;
    case (item_i.operation)
      OP_TICK:       go_mul  = playing_q;
      OP_START:      go_push = 1'b1;
      OP_STOP:       go_push = 1'b1;
      OP_WRITE_STEP: go_push = 1'b1;
      default:       go_push = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && go_mul) begin
          state_d = F_MUL;
        end else if (accept && go_push) begin
          state_d = F_PUSH;
        end
      end
      F_MUL:  state_d = F_MOD;
      F_MOD: begin
        if (bit_q == 5'd0) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!cmd_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign prod    = 64'(tick_q) * 64'(DIV6_RECIP);
  assign shifted = (rem_q[3:0] >= 4'(len_i) && len_i != 5'd16) ? 5'd0 : 5'd0;
  assign low6    = {3'b000, quo_q[2:0]} * 6'(TICKS_PER_STEP);
  assign phase   = tick_q[2:0] - low6[2:0];

  always_comb begin
    if (swing_i != 2'd0 && rem_q[0]) begin
      fire = (phase == {1'b0, swing_i});
    end else begin
      fire = (phase == 3'd0);
    end
  end

  always_comb begin
    logic [4:0] r2;
    playing_d = playing_q;
    tick_d    = tick_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    cmd_d     = cmd_q;
    r2        = {rem_q[3:0], quo_q[bit_q]};
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          tick_d           = item_i.tick_count;
          cmd_d.tick       = item_i.tick_count;
          cmd_d.track      = item_i.track_index;
          cmd_d.step       = item_i.step_index;
          cmd_d.fire       = 1'b0;
          cmd_d.entry      = {item_i.step_active, item_i.step_note, item_i.step_velocity,
                              item_i.step_accent, item_i.step_length};
          cmd_d.kind       = CMD_TICK;
          case (item_i.operation)
            OP_START: begin
              playing_d  = 1'b1;
              cmd_d.kind = CMD_START;
            end
            OP_STOP: begin
              playing_d  = 1'b0;
              cmd_d.kind = CMD_STOP;
            end
            OP_CONTINUE:   playing_d  = 1'b1;
            OP_WRITE_STEP: cmd_d.kind = CMD_WRITE;
            default:       cmd_d.kind = CMD_TICK;
          endcase
        end
      end
      F_MUL: begin
        quo_d = prod[DIV6_SHIFT +: QUO_W];
        rem_d = 5'd0;
        bit_d = 5'(QUO_W - 1);
      end
      F_MOD: begin
        // one quotient bit per cycle into the remainder by pattern length
        if (r2 >= len_i) begin
          rem_d = r2 - len_i;
        end else begin
          rem_d = r2 + shifted;
        end
        bit_d = bit_q - 5'd1;
      end
      F_PUSH: begin
        if (cmd_q.kind == CMD_TICK) begin
          cmd_d.step = rem_q[3:0];
          cmd_d.fire = fire;
        end
      end
      default: cmd_d = cmd_q;
    endcase
  end

  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;

  always_comb begin
    cmd_o = cmd_q;
    if (cmd_q.kind == CMD_TICK) begin
      cmd_o.step = rem_q[3:0];
      cmd_o.fire = fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      playing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      playing_q <= playing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    cmd_q  <= cmd_d;
  end

endmodule

/* hw/rtl/mss_cmd_q.sv */
// Two-entry command queue between the front end and the back end.
// Depends on mss_pkg.
module mss_cmd_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mss_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output mss_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import mss_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

/* hw/rtl/mss_back.sv */
// Back end: step store, note triggering, held-note list and result queue.
// Depends on mss_pkg, mss_ram and the assertion macro header.
`include "midi_step_sequencer_unit_assert.svh"
module mss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mss_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  mss_pkg::play_cfg_t  cfg_i,
  output mss_pkg::out_item_t  out_o,
  output logic                out_empty_o,
  input  logic                out_pop_i
);
  import mss_pkg::*;

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE, B_FIRE_RD, B_FIRE_EV, B_ADVANCE, B_COMPLETE, B_RELEASE, B_START_ADV, B_FLUSH
  } back_state_e;

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [3:0]  cur_step_q;
  logic [31:0] cur_tick_q;
  logic [TRK_W-1:0] trk_q;
  logic [CNT_W-1:0] rd_q, keep_q, count_q;
  logic        rel_all_q;
  logic [TRACKS*STEPS-1:0] vld_q;
  logic        rd_vld_q;

  logic [6:0]  h_note_q [NOTE_SLOTS];
  logic [3:0]  h_chan_q [NOTE_SLOTS];
  logic [31:0] h_end_q  [NOTE_SLOTS];

  out_item_t   pend_q;
  logic        pend_v_q;
  out_item_t   omem_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_q, ord_q;
  logic [OPTR_W:0]   ocnt_q;

  logic        room, out_pop;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  step_entry_t ram_rdata, entry;

  mss_ram #(.WIDTH(ENTRY_W), .DEPTH(TRACKS * STEPS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign room      = (ocnt_q < (OPTR_W+1)'(OUT_DEPTH));
  assign cmd_pop_o = (state_q == B_IDLE) && !cmd_empty_i;
  assign ram_we    = cmd_pop_o && (cmd_i.kind == CMD_WRITE);
  assign ram_waddr = {cmd_i.track, cmd_i.step};
  assign ram_raddr = {trk_q, cur_step_q};
  assign entry     = rd_vld_q ? ram_rdata : '0;

  // Note-on evaluation for the track under the read pointer
  logic        any_solo, allowed, note_fire;
  logic signed [6:0] trn;
  logic signed [8:0] note_sum;
  logic [6:0]  note_sat;
  logic [7:0]  vel_sum;
  logic [6:0]  vel_sat;
  logic [3:0]  chan;
  logic [5:0]  trn_raw;
  logic        expired;
  logic [SLOT_W-1:0] rd_idx;

  assign any_solo  = |cfg_i.solo;
  assign allowed   = !(any_solo && !cfg_i.solo[trk_q]) && !(cfg_i.mute[trk_q] && !cfg_i.solo[trk_q]);
  assign note_fire = allowed && entry.active;
  assign trn_raw   = cfg_i.transpose[6*trk_q +: 6];

  always_comb begin
    trn = 7'(signed'(trn_raw));
    if (trn > 7'(TRANSPOSE_LIMIT)) begin
      trn = 7'(TRANSPOSE_LIMIT);
    end else if (trn < -7'(TRANSPOSE_LIMIT)) begin
      trn = -7'(TRANSPOSE_LIMIT);
    end
    note_sum = signed'({2'b00, entry.note}) + 9'(trn);
    if (note_sum < 9'sd0) begin
      note_sat = 7'd0;
    end else if (note_sum > 9'(NOTE_MAX)) begin
      note_sat = 7'(NOTE_MAX);
    end else begin
      note_sat = note_sum[6:0];
    end
    vel_sum = {1'b0, entry.velocity} + (entry.accent ? 8'(ACCENT_BOOST) : 8'd0);
    vel_sat = (vel_sum > 8'(NOTE_MAX)) ? 7'(NOTE_MAX) : vel_sum[6:0];
  end

  assign chan    = 4'(trk_q) + 4'd1;
  assign rd_idx  = rd_q[SLOT_W-1:0];
  assign expired = rel_all_q || (cur_tick_q >= h_end_q[rd_idx]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.kind)
            CMD_START, CMD_STOP: state_d = B_RELEASE;
            CMD_TICK: begin
              if (cmd_i.fire && cmd_i.step != cur_step_q) begin
                state_d = B_FIRE_RD;
              end else begin
                state_d = B_RELEASE;
              end
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_FIRE_RD: state_d = B_FIRE_EV;
      B_FIRE_EV: begin
        if (room) begin
          state_d = (trk_q == TRK_W'(TRACKS - 1)) ? B_ADVANCE : B_FIRE_RD;
        end
      end
      B_ADVANCE: begin
        if (room) begin
          state_d = (cur_step_q == 4'd0) ? B_COMPLETE : B_RELEASE;
        end
      end
      B_COMPLETE: begin
        if (room) begin
          state_d = B_RELEASE;
        end
      end
      B_RELEASE: begin
        if (room && rd_q == count_q) begin
          state_d = (cmd_q.kind == CMD_START) ? B_START_ADV : B_FLUSH;
        end
      end
      B_START_ADV: begin
        if (room) begin
          state_d = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (room) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Result emission: hold one result back so the last of an item can be marked
  logic      emit_v, push_v, slot_we;
  out_item_t emit_item, push_item;
  logic [SLOT_W-1:0] slot_waddr;
  logic [6:0]  slot_note;
  logic [3:0]  slot_chan;
  logic [31:0] slot_end;

  always_comb begin
    emit_v     = 1'b0;
    emit_item  = '0;
    slot_we    = 1'b0;
    slot_waddr = keep_q[SLOT_W-1:0];
    slot_note  = h_note_q[rd_idx];
    slot_chan  = h_chan_q[rd_idx];
    slot_end   = h_end_q[rd_idx];
    case (state_q)
      B_FIRE_EV: begin
        if (room && note_fire) begin
          emit_v                 = 1'b1;
          emit_item.event_kind   = EV_NOTE_ON;
          emit_item.track_out    = trk_q;
          emit_item.step_out     = cur_step_q;
          emit_item.note_out     = note_sat;
          emit_item.velocity_out = vel_sat;
          emit_item.channel_out  = chan;
          if (count_q < CNT_W'(NOTE_SLOTS)) begin
            slot_we    = 1'b1;
            slot_waddr = count_q[SLOT_W-1:0];
            slot_note  = note_sat;
            slot_chan  = chan;
            slot_end   = cur_tick_q + 32'(entry.length);
          end
        end
      end
      B_ADVANCE, B_START_ADV: begin
        if (room) begin
          emit_v               = 1'b1;
          emit_item.event_kind = EV_ADVANCE;
          emit_item.step_out   = cur_step_q;
        end
      end
      B_COMPLETE: begin
        if (room) begin
          emit_v               = 1'b1;
          emit_item.event_kind = EV_COMPLETE;
        end
      end
      B_RELEASE: begin
        if (room && rd_q != count_q) begin
          if (expired) begin
            emit_v                = 1'b1;
            emit_item.event_kind  = EV_NOTE_OFF;
            emit_item.note_out    = h_note_q[rd_idx];
            emit_item.channel_out = h_chan_q[rd_idx];
          end else begin
            slot_we = 1'b1;
          end
        end
      end
      default: emit_v = 1'b0;
    endcase
  end

  always_comb begin
    push_v    = 1'b0;
    push_item = pend_q;
    if (emit_v && pend_v_q) begin
      push_v = 1'b1;
    end else if (state_q == B_FLUSH && room && pend_v_q) begin
      push_v         = 1'b1;
      push_item.last = 1'b1;
    end
  end

  assign out_empty_o = (ocnt_q == '0);
  assign out_pop     = out_pop_i && !out_empty_o;
  assign out_o       = omem_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      cur_step_q <= 4'd0;
      cur_tick_q <= 32'd0;
      count_q    <= '0;
      vld_q      <= '0;
      pend_v_q   <= 1'b0;
      owr_q      <= '0;
      ord_q      <= '0;
      ocnt_q     <= '0;
      trk_q      <= '0;
      rd_q       <= '0;
      keep_q     <= '0;
      rel_all_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (cmd_pop_o) begin
        rd_q   <= '0;
        keep_q <= '0;
        trk_q  <= '0;
        case (cmd_i.kind)
          CMD_START: begin
            cur_step_q <= 4'd0;
            cur_tick_q <= 32'd0;
            rel_all_q  <= 1'b1;
          end
          CMD_STOP:  rel_all_q <= 1'b1;
          CMD_TICK: begin
            cur_tick_q <= cmd_i.tick;
            rel_all_q  <= 1'b0;
            if (cmd_i.fire && cmd_i.step != cur_step_q) begin
              cur_step_q <= cmd_i.step;
            end
          end
          default: rel_all_q <= rel_all_q;
        endcase
      end
      if (state_q == B_FIRE_EV && room) begin
        trk_q <= trk_q + TRK_W'(1);
        if (note_fire && count_q < CNT_W'(NOTE_SLOTS)) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (state_q == B_RELEASE && room) begin
        if (rd_q == count_q) begin
          count_q <= keep_q;
        end else begin
          rd_q <= rd_q + CNT_W'(1);
          if (!expired) begin
            keep_q <= keep_q + CNT_W'(1);
          end
        end
      end
      if (emit_v) begin
        pend_v_q <= 1'b1;
      end else if (push_v) begin
        pend_v_q <= 1'b0;
      end
      if (push_v) begin
        owr_q <= owr_q + OPTR_W'(1);
      end
      if (out_pop) begin
        ord_q <= ord_q + OPTR_W'(1);
      end
      ocnt_q <= ocnt_q + (OPTR_W+1)'(push_v) - (OPTR_W+1)'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    rd_vld_q <= vld_q[ram_raddr];
    if (emit_v) begin
      pend_q <= emit_item;
    end
    if (push_v) begin
      omem_q[owr_q] <= push_item;
    end
    if (slot_we) begin
      h_note_q[slot_waddr] <= slot_note;
      h_chan_q[slot_waddr] <= slot_chan;
      h_end_q[slot_waddr]  <= slot_end;
    end
  end

  `MSS_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(NOTE_SLOTS), "held count overflow")
  `MSS_ASSERT_IMP(a_keep_behind, clk_i, rst_ni, state_q == B_RELEASE, keep_q <= rd_q, "compaction passed reader")
  `MSS_ASSERT_NEVER(a_idle_pend, clk_i, rst_ni, state_q == B_IDLE && pend_v_q, "result left unflushed")
  `MSS_ASSERT_NEVER(a_out_ovf, clk_i, rst_ni, push_v && ocnt_q == (OPTR_W+1)'(OUT_DEPTH), "result queue overflow")

endmodule
